>>> sv/scsm_pkg.sv
package scsm_pkg;

  localparam int unsigned REG_BITS = 17;
  localparam int unsigned REG_IDX_BITS = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_DRIVE = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_TONE  = 2'd1;

  localparam logic [REG_BITS-1:0] Q16_ONE = 17'h10000;
  localparam logic [REG_BITS:0] MIX_ONE = 18'h20000;

  localparam int unsigned GAIN_BITS = 21;
  localparam int unsigned GAIN_STEP = 15;
  localparam int unsigned Q16_SHIFT = 16;
  localparam int unsigned MIX_SHIFT = 17;

  typedef struct packed {
    logic valid;
    logic stall;
  } hs_t;

  function automatic logic [REG_BITS-1:0] clamp_q16(input logic [REG_BITS-1:0] v);
    return (v > Q16_ONE) ? Q16_ONE : v;
  endfunction

endpackage

>>> sv/soft_clip_saturator_mix.sv
// Soft-clip saturator with dry/wet tone mix for a stream of signed Q3.20 samples.
// Input channel: sample_in_i is taken when sample_in_valid_i is high and
// sample_in_stall_o is low. Output channel: sample_out_o is taken when
// sample_out_valid_o is high and sample_out_stall_i is low.
// Throughput is one sample per cycle while sample_out_stall_i stays low; every stage works on its own sample.
// The pipeline has three gain stages, one stage per quotient bit of the
// soft-clip divider (SAMPLE_BITS - 3 bits) and three mix, round and
// saturate stages.
// A stalled receiver holds the output register; stages upstream keep filling
// empty slots, so the input stalls only once the pipeline is full.
// Reset clears all valid bits and sets drive and tone to zero.
// Write drive (index 0) and tone (index 1) through cfg_we_i only while no
// transaction is in flight; values above 1.0 act as 1.0, other indexes are
// ignored.
module soft_clip_saturator_mix #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [scsm_pkg::REG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [scsm_pkg::REG_BITS-1:0]       cfg_wdata_i,
  input  logic                                sample_in_valid_i,
  output logic                                sample_in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in_i,
  output logic                                sample_out_valid_o,
  input  logic                                sample_out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_out_o
);
  import scsm_pkg::*;

  localparam int unsigned FB = SAMPLE_BITS - 4;
  localparam int unsigned DW = SAMPLE_BITS + 6;

  logic [REG_BITS-1:0] drive_q, tone_q;
  logic [REG_BITS-1:0] drive_c, tone_c;

  hs_t gain_hs, div_hs;

  logic [DW-1:0]                 g_den, g_rem;
  logic [FB:0]                   g_nlow;
  logic                          g_neg, d_neg;
  logic signed [SAMPLE_BITS-1:0] g_x, d_x;
  logic [FB:0]                   d_ymag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= '0;
      tone_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DRIVE: drive_q <= cfg_wdata_i;
        REG_TONE:  tone_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign drive_c = clamp_q16(drive_q);
  assign tone_c  = clamp_q16(tone_q);

  scsm_gain #(.SAMPLE_BITS(SAMPLE_BITS)) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .drive_i (drive_c),
    .valid_i (sample_in_valid_i),
    .stall_o (sample_in_stall_o),
    .x_i     (sample_in_i),
    .valid_o (gain_hs.valid),
    .stall_i (gain_hs.stall),
    .den_o   (g_den),
    .rem_o   (g_rem),
    .nlow_o  (g_nlow),
    .neg_o   (g_neg),
    .x_o     (g_x)
  );

  scsm_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (gain_hs.valid),
    .stall_o (gain_hs.stall),
    .den_i   (g_den),
    .rem_i   (g_rem),
    .nlow_i  (g_nlow),
    .neg_i   (g_neg),
    .x_i     (g_x),
    .valid_o (div_hs.valid),
    .stall_i (div_hs.stall),
    .ymag_o  (d_ymag),
    .neg_o   (d_neg),
    .x_o     (d_x)
  );

  scsm_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tone_i   (tone_c),
    .valid_i  (div_hs.valid),
    .stall_o  (div_hs.stall),
    .ymag_i   (d_ymag),
    .neg_i    (d_neg),
    .x_i      (d_x),
    .valid_o  (sample_out_valid_o),
    .stall_i  (sample_out_stall_i),
    .sample_o (sample_out_o)
  );

endmodule

>>> sv/scsm_gain.sv
module scsm_gain #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [scsm_pkg::REG_BITS-1:0]    drive_i,
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic signed [SAMPLE_BITS-1:0]    x_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic [SAMPLE_BITS+5:0]           den_o,
  output logic [SAMPLE_BITS+5:0]           rem_o,
  output logic [SAMPLE_BITS-4:0]           nlow_o,
  output logic                             neg_o,
  output logic signed [SAMPLE_BITS-1:0]    x_o
);
  import scsm_pkg::*;

  localparam int unsigned FB = SAMPLE_BITS - 4;
  localparam int unsigned PW = SAMPLE_BITS + GAIN_BITS;
  localparam int unsigned MW = SAMPLE_BITS + 5;
  localparam int unsigned DW = SAMPLE_BITS + 6;
  localparam int unsigned NW = MW + FB + 1;

  logic rdy1, rdy2, rdy3;

  logic                          v1_q, v2_q, v3_q;
  logic [SAMPLE_BITS-1:0]        xmag1_q;
  logic [GAIN_BITS-1:0]          g1_q;
  logic                          neg1_q, neg2_q, neg3_q;
  logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, x3_q;
  logic [PW-1:0]                 prod2_q;
  logic [DW-1:0]                 den3_q, rem3_q;
  logic [FB:0]                   nlow3_q;

  logic [SAMPLE_BITS-1:0] xmag_d;
  logic [GAIN_BITS-1:0]   g_d;
  logic [PW-1:0]          msum;
  logic [MW-1:0]          m_d;
  logic [DW-1:0]          den_d;
  logic [NW-1:0]          num_d;

  assign rdy3    = !v3_q || !stall_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign stall_o = !rdy1;

  assign xmag_d = x_i[SAMPLE_BITS-1] ? (~x_i + 1'b1) : x_i;
  assign g_d    = GAIN_BITS'(Q16_ONE) + GAIN_BITS'(drive_i) * GAIN_BITS'(GAIN_STEP);

  assign msum  = prod2_q + PW'(1 << (Q16_SHIFT - 1));
  assign m_d   = MW'(msum >> Q16_SHIFT);
  assign den_d = DW'(1) << FB | DW'(0);
  assign num_d = (NW'(m_d) << FB) + NW'((den_d + DW'(m_d)) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      xmag1_q <= xmag_d;
      g1_q    <= g_d;
      neg1_q  <= x_i[SAMPLE_BITS-1];
      x1_q    <= x_i;
    end
    if (rdy2 && v1_q) begin
      prod2_q <= PW'(xmag1_q) * PW'(g1_q);
      neg2_q  <= neg1_q;
      x2_q    <= x1_q;
    end
    if (rdy3 && v2_q) begin
      den3_q  <= den_d + DW'(m_d);
      rem3_q  <= DW'(num_d[NW-1:FB+1]);
      nlow3_q <= num_d[FB:0];
      neg3_q  <= neg2_q;
      x3_q    <= x2_q;
    end
  end

  assign valid_o = v3_q;
  assign den_o   = den3_q;
  assign rem_o   = rem3_q;
  assign nlow_o  = nlow3_q;
  assign neg_o   = neg3_q;
  assign x_o     = x3_q;

endmodule

>>> sv/scsm_div.sv
module scsm_div #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [SAMPLE_BITS+5:0]        den_i,
  input  logic [SAMPLE_BITS+5:0]        rem_i,
  input  logic [SAMPLE_BITS-4:0]        nlow_i,
  input  logic                          neg_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [SAMPLE_BITS-4:0]        ymag_o,
  output logic                          neg_o,
  output logic signed [SAMPLE_BITS-1:0] x_o
);
  import scsm_pkg::*;

  localparam int unsigned QW = SAMPLE_BITS - 3;
  localparam int unsigned DW = SAMPLE_BITS + 6;

  logic                          src_v   [QW+1];
  logic [DW-1:0]                 src_den [QW+1];
  logic [DW-1:0]                 src_rem [QW+1];
  logic [QW-1:0]                 src_nb  [QW+1];
  logic [QW-1:0]                 src_q   [QW+1];
  logic                          src_neg [QW+1];
  logic signed [SAMPLE_BITS-1:0] src_x   [QW+1];
  logic                          rdy     [QW+1];

  assign src_v[0]   = valid_i;
  assign src_den[0] = den_i;
  assign src_rem[0] = rem_i;
  assign src_nb[0]  = nlow_i;
  assign src_q[0]   = '0;
  assign src_neg[0] = neg_i;
  assign src_x[0]   = x_i;
  assign rdy[QW]    = !stall_i;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0]   rem2;
    logic [DW:0]   diff;
    logic          take;
    logic          v_q;
    logic [DW-1:0] den_q, rem_q;
    logic [QW-1:0] nb_q, q_q;
    logic          neg_q;
    logic signed [SAMPLE_BITS-1:0] x_q;

    assign rem2 = {src_rem[i], src_nb[i][QW-1]};
    assign diff = rem2 - {1'b0, src_den[i]};
    assign take = rem2 >= {1'b0, src_den[i]};
    assign rdy[i] = !v_q || rdy[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[i]) begin
        v_q <= src_v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && src_v[i]) begin
        den_q <= src_den[i];
        rem_q <= take ? diff[DW-1:0] : rem2[DW-1:0];
        nb_q  <= src_nb[i] << 1;
        q_q   <= {src_q[i][QW-2:0], take};
        neg_q <= src_neg[i];
        x_q   <= src_x[i];
      end
    end

    assign src_v[i+1]   = v_q;
    assign src_den[i+1] = den_q;
    assign src_rem[i+1] = rem_q;
    assign src_nb[i+1]  = nb_q;
    assign src_q[i+1]   = q_q;
    assign src_neg[i+1] = neg_q;
    assign src_x[i+1]   = x_q;
  end

  assign stall_o = !rdy[0];
  assign valid_o = src_v[QW];
  assign ymag_o  = src_q[QW];
  assign neg_o   = src_neg[QW];
  assign x_o     = src_x[QW];

endmodule

>>> sv/scsm_mix.sv
module scsm_mix #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [scsm_pkg::REG_BITS-1:0] tone_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [SAMPLE_BITS-4:0]        ymag_i,
  input  logic                          neg_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);
  import scsm_pkg::*;

  localparam int unsigned QW = SAMPLE_BITS - 3;
  localparam int unsigned SW = SAMPLE_BITS + 20;
  localparam int unsigned RW = SW - MIX_SHIFT + 1;

  logic rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q;
  logic signed [SW-1:0] py1_q, px1_q, s2_q;
  logic signed [SAMPLE_BITS-1:0] out3_q;

  logic signed [QW:0]     y_d;
  logic [REG_BITS:0]      wet_d;
  logic [SW-1:0]          smag;
  logic [RW-1:0]          rmag;
  logic                   sneg;
  logic [RW-1:0]          max_pos, max_neg;
  logic signed [SAMPLE_BITS-1:0] out_d;

  assign rdy3    = !v3_q || !stall_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign stall_o = !rdy1;

  assign y_d   = neg_i ? -$signed({1'b0, ymag_i}) : $signed({1'b0, ymag_i});
  assign wet_d = MIX_ONE - (REG_BITS+1)'(tone_i);

  assign sneg    = s2_q[SW-1];
  assign smag    = sneg ? SW'(-s2_q) : SW'(s2_q);
  assign rmag    = RW'((smag + SW'(1 << (MIX_SHIFT - 1))) >> MIX_SHIFT);
  assign max_pos = (RW'(1) << (SAMPLE_BITS - 1)) - RW'(1);
  assign max_neg = RW'(1) << (SAMPLE_BITS - 1);

  always_comb begin
    if (sneg) begin
      out_d = (rmag > max_neg) ? SAMPLE_BITS'(max_neg) : SAMPLE_BITS'(-rmag);
    end else begin
      out_d = (rmag > max_pos) ? SAMPLE_BITS'(max_pos) : SAMPLE_BITS'(rmag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      py1_q <= y_d * $signed({1'b0, wet_d});
      px1_q <= x_i * $signed({1'b0, tone_i});
    end
    if (rdy2 && v1_q) begin
      s2_q <= py1_q + px1_q;
    end
    if (rdy3 && v2_q) begin
      out3_q <= out_d;
    end
  end

  assign valid_o  = v3_q;
  assign sample_o = out3_q;

endmodule
